// File: hw/rtl/boundary_pixel_neighbor_labels_macros.svh
// ----------------------------------------------------------------------------
// boundary pixel neighbor labels: assertion macros
// concurrent checks, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef BOUNDARY_PIXEL_NEIGHBOR_LABELS_MACROS_SVH
`define BOUNDARY_PIXEL_NEIGHBOR_LABELS_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define BPNL_ASSERT_IMPL(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("bpnl assertion failed");
// next-cycle implication
`define BPNL_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("bpnl assertion failed");
`else
`define BPNL_ASSERT_IMPL(lbl, clk, rst_n, a, b)
`define BPNL_ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif

`endif

// File: hw/rtl/bpnl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpnl_pkg
// shared types, constants and helpers of the boundary label block
// ----------------------------------------------------------------------------
package bpnl_pkg;

    localparam int LABEL_W   = 32;
    localparam int POS_W     = 29;
    localparam int CNT_W     = 4;
    localparam int NBR       = 8;
    localparam int PHASE_W   = 4;
    localparam int W_W       = 17;
    localparam int H_REG_W   = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;

    localparam logic [W_W-1:0] W_MAX = 17'd65536;

    typedef struct packed {
        logic               op;
        logic [LABEL_W-1:0] label;
    } t_in;

    typedef struct packed {
        logic [POS_W-1:0]   position;
        logic [LABEL_W-1:0] neighbor_label;
        logic [CNT_W-1:0]   neighbor_count;
        logic               last;
    } t_out;

    // one sorter entry, an empty entry orders above every label
    typedef struct packed {
        logic               vld;
        logic [LABEL_W-1:0] lbl;
    } t_slot;

    typedef struct packed {
        logic [POS_W-1:0]      pos;
        t_slot [NBR-1:0]       slots;
    } t_job;

    function automatic logic slot_gt(input t_slot a, input t_slot b);
        slot_gt = (!a.vld && b.vld) || (a.vld && b.vld && (a.lbl > b.lbl));
    endfunction

endpackage

// File: hw/rtl/boundary_pixel_neighbor_labels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boundary_pixel_neighbor_labels
// neighbor labels of zero-labelled pixels in a column-major label stream
// ----------------------------------------------------------------------------
//  channel  direction  handshake               payload
//  in       input      i_in_valid/o_in_ready   t_in  (op, label)
//  out      output     o_out_valid/i_out_ready t_out (position, label, count, last)
//  cfg      input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
//  a pixel that yields no result is taken back to back
//  a boundary pixel holds the sort chain for one load and eight compare
//  phases, results leave through a shift chain while the next sorts
//  the column memory gives one read and one write a cycle, reads registered
//  synchronous active-low reset clears counters and valid flags, sizes to one
//  a boundary pixel holds off the next request while its job passes the
//  window stage and the job slot to the sort chain; a full job slot or a
//  stalled result chain holds off requests longer
// ----------------------------------------------------------------------------
`include "boundary_pixel_neighbor_labels_macros.svh"

module boundary_pixel_neighbor_labels import bpnl_pkg::*; #(
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int MW = 2 * LABEL_W;

    // configuration
    logic [HW-1:0]  r_h_eff;
    logic [W_W-1:0] r_w_eff;
    logic [HW-1:0]  n_h_eff;
    logic [W_W-1:0] n_w_eff;
    logic           w_cfg_wr;
    logic           w_cfg_hit;

    // stream and centre counters
    logic [RW-1:0]    r_qr, n_qr;
    logic [W_W-1:0]   r_qc, n_qc;
    logic [RW-1:0]    r_pr, n_pr;
    logic [W_W-1:0]   r_pc, n_pc;
    logic [POS_W-1:0] r_pos, n_pos;

    logic             w_in_acc;
    logic             w_live;
    logic             w_proc;
    logic             w_h_last;
    logic [W_W-1:0]   w_w_m1;
    logic             w_end;
    logic [LABEL_W-1:0] w_label;

    // window stage
    logic               r_s1_valid;
    logic [LABEL_W-1:0] r_s1_label;
    logic [RW-1:0]      r_s1_row;
    logic               r_s1_proc;
    logic               r_s1_left_ok;
    logic               r_s1_right_ok;
    logic               r_s1_top_ok;
    logic               r_s1_bot_ok;
    logic [POS_W-1:0]   r_s1_pos;
    logic               r_fwd;
    logic [MW-1:0]      r_fwd_word;
    logic [MW-1:0]      w_mem_rd;
    logic [MW-1:0]      w_rd_eff;
    logic [LABEL_W-1:0] w_rd1;
    logic [LABEL_W-1:0] w_rd2;
    logic [LABEL_W-1:0] r_win [3][3];
    logic               w_s1_job;
    t_job               w_job;

    // job slot
    logic r_job_valid;
    t_job r_job;
    logic w_job_take;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid;
    assign w_cfg_hit   = w_cfg_wr && ((i_cfg_index == REG_HEIGHT) ||
                                      (i_cfg_index == REG_WIDTH));

    // clamp written sizes to the supported range
    always_comb begin
        if (i_cfg_data[H_REG_W-1:0] == '0) begin
            n_h_eff = HW'(1);
        end else if (32'(i_cfg_data[H_REG_W-1:0]) > 32'(MAX_HEIGHT)) begin
            n_h_eff = HW'(MAX_HEIGHT);
        end else begin
            n_h_eff = HW'(i_cfg_data[H_REG_W-1:0]);
        end
        if (i_cfg_data[W_W-1:0] == '0) begin
            n_w_eff = W_W'(1);
        end else if (i_cfg_data[W_W-1:0] > W_MAX) begin
            n_w_eff = W_MAX;
        end else begin
            n_w_eff = i_cfg_data[W_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_eff <= HW'(1);
            r_w_eff <= W_W'(1);
        end else if (w_cfg_wr) begin
            case (i_cfg_index)
                REG_HEIGHT: r_h_eff <= n_h_eff;
                REG_WIDTH:  r_w_eff <= n_w_eff;
                default:    ;
            endcase
        end
    end

    // input request accepted
    assign w_in_acc = i_in_valid && o_in_ready;
    assign w_label  = i_in_data.op ? '0 : i_in_data.label;

    // centre lags the stream by one column and one row
    assign w_live   = (r_qc > W_W'(1)) || ((r_qc == W_W'(1)) && (r_qr != '0));
    assign w_proc   = w_live && (r_pc < r_w_eff);
    assign w_w_m1   = r_w_eff - W_W'(1);
    assign w_h_last = (32'(r_pr) + 32'd1) == 32'(r_h_eff);
    assign w_end    = w_proc && (r_pc == w_w_m1) && w_h_last;

    // next stream and centre position
    always_comb begin
        n_qr  = r_qr;
        n_qc  = r_qc;
        n_pr  = r_pr;
        n_pc  = r_pc;
        n_pos = r_pos;
        if ((32'(r_qr) + 32'd1) >= 32'(r_h_eff)) begin
            n_qr = '0;
            n_qc = r_qc + W_W'(1);
        end else begin
            n_qr = r_qr + RW'(1);
        end
        if (32'(n_qc) > (32'(r_w_eff) + 32'd1)) begin
            n_qr = '0;
            n_qc = '0;
        end
        if (w_live) begin
            n_pos = r_pos + POS_W'(1);
            if (w_h_last) begin
                n_pr = '0;
                n_pc = r_pc + W_W'(1);
            end else begin
                n_pr = r_pr + RW'(1);
            end
        end
        if (w_end) begin
            n_qr  = '0;
            n_qc  = '0;
            n_pr  = '0;
            n_pc  = '0;
            n_pos = POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_cfg_hit) begin
            r_qr  <= '0;
            r_qc  <= '0;
            r_pr  <= '0;
            r_pc  <= '0;
            r_pos <= POS_W'(1);
        end else if (w_in_acc) begin
            r_qr  <= n_qr;
            r_qc  <= n_qc;
            r_pr  <= n_pr;
            r_pc  <= n_pc;
            r_pos <= n_pos;
        end
    end

    // capture the request and its centre bounds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_label    <= w_label;
            r_s1_row      <= r_qr;
            r_s1_proc     <= w_proc;
            r_s1_left_ok  <= (r_pc != '0);
            r_s1_right_ok <= (r_pc != w_w_m1);
            r_s1_top_ok   <= (r_pr != '0);
            r_s1_bot_ok   <= !w_h_last;
            r_s1_pos      <= r_pos;
            r_fwd         <= r_s1_valid && (r_s1_row == r_qr);
            r_fwd_word    <= {w_rd1, r_s1_label};
        end
    end

    // two column delays in one word: upper half two columns back
    bpnl_line_buf #(
        .DEPTH (MAX_HEIGHT),
        .AW    (RW),
        .DW    (MW)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rd_en   (w_in_acc),
        .i_rd_addr (r_qr),
        .i_wr_en   (r_s1_valid),
        .i_wr_addr (r_s1_row),
        .i_wr_data ({w_rd1, r_s1_label}),
        .o_rd_data (w_mem_rd)
    );

    // bypass when the previous request wrote the row being read
    assign w_rd_eff = r_fwd ? r_fwd_word : w_mem_rd;
    assign w_rd1    = w_rd_eff[LABEL_W-1:0];
    assign w_rd2    = w_rd_eff[MW-1:LABEL_W];

    // 3x3 window columns shift down one row per request
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_win[0][0] <= w_rd2;
            r_win[1][0] <= w_rd1;
            r_win[2][0] <= r_s1_label;
            for (int c = 0; c < 3; c++) begin
                r_win[c][1] <= r_win[c][0];
                r_win[c][2] <= r_win[c][1];
            end
        end
    end

    // neighbor slots of the centre, masked at the image edges
    always_comb begin
        w_job.pos = r_s1_pos;
        w_job.slots[0].lbl = r_win[0][1];
        w_job.slots[1].lbl = r_win[0][0];
        w_job.slots[2].lbl = w_rd2;
        w_job.slots[3].lbl = r_win[1][1];
        w_job.slots[4].lbl = w_rd1;
        w_job.slots[5].lbl = r_win[2][1];
        w_job.slots[6].lbl = r_win[2][0];
        w_job.slots[7].lbl = r_s1_label;
        w_job.slots[0].vld = r_s1_left_ok && r_s1_top_ok;
        w_job.slots[1].vld = r_s1_left_ok;
        w_job.slots[2].vld = r_s1_left_ok && r_s1_bot_ok;
        w_job.slots[3].vld = r_s1_top_ok;
        w_job.slots[4].vld = r_s1_bot_ok;
        w_job.slots[5].vld = r_s1_right_ok && r_s1_top_ok;
        w_job.slots[6].vld = r_s1_right_ok;
        w_job.slots[7].vld = r_s1_right_ok && r_s1_bot_ok;
        for (int i = 0; i < NBR; i++) begin
            w_job.slots[i].vld = w_job.slots[i].vld && (w_job.slots[i].lbl != '0);
        end
    end

    assign w_s1_job   = r_s1_valid && r_s1_proc && (r_win[1][0] == '0);
    assign o_in_ready = !r_job_valid && !w_s1_job;

    // job slot toward the sort chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
        end else if (w_s1_job) begin
            r_job_valid <= 1'b1;
        end else if (w_job_take) begin
            r_job_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_job) begin
            r_job <= w_job;
        end
    end

    bpnl_sorter u_sorter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (r_job_valid),
        .i_job       (r_job),
        .o_job_take  (w_job_take),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // checks
    `BPNL_ASSERT_IMPL(a_job_slot_free, i_clk, i_rst_n, w_s1_job, !r_job_valid)
    `BPNL_ASSERT_NEXT(a_accept_to_window, i_clk, i_rst_n, w_in_acc, r_s1_valid)
    `BPNL_ASSERT_IMPL(a_empty_is_last, i_clk, i_rst_n, o_out_valid && (o_out_data.neighbor_count == '0), o_out_data.last)

endmodule

// File: hw/rtl/bpnl_line_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpnl_line_buf
// column delay memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module bpnl_line_buf #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 64
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/bpnl_sort_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpnl_sort_cell
// one entry of the transposition sort chain, swaps with a neighbor
// ----------------------------------------------------------------------------
module bpnl_sort_cell import bpnl_pkg::*; (
    input  logic  i_clk,
    input  logic  i_load,
    input  t_slot i_load_val,
    input  logic  i_step,
    input  logic  i_lower,
    input  logic  i_upper,
    input  t_slot i_left,
    input  t_slot i_right,
    output t_slot o_val
);

    t_slot r_val;
    t_slot n_val;

    // keep the smaller as lower half of a pair, the larger as upper half
    always_comb begin
        n_val = r_val;
        if (i_load) begin
            n_val = i_load_val;
        end else if (i_step) begin
            if (i_lower && slot_gt(r_val, i_right)) begin
                n_val = i_right;
            end else if (i_upper && slot_gt(i_left, r_val)) begin
                n_val = i_left;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;

endmodule

// File: hw/rtl/bpnl_sorter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpnl_sorter
// sort chain of eight cells, duplicate removal and result shift chain
// ----------------------------------------------------------------------------
module bpnl_sorter import bpnl_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_job_valid,
    input  t_job i_job,
    output logic o_job_take,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam logic [PHASE_W-1:0] PH_DONE = PHASE_W'(NBR);

    logic               r_busy;
    logic [PHASE_W-1:0] r_phase;
    logic [POS_W-1:0]   r_pos;

    logic [NBR-1:0]     r_keep;
    logic [LABEL_W-1:0] r_ol [NBR];
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   r_left;
    logic [POS_W-1:0]   r_out_pos;

    t_slot              w_cell [NBR];
    logic               w_done;
    logic               w_xfer;
    logic               w_take;
    logic               w_step;
    logic [NBR-1:0]     w_keep;
    logic [CNT_W-1:0]   w_cnt;
    logic               w_adv;

    assign w_done = r_busy && (r_phase == PH_DONE);
    assign w_xfer = w_done && !(|r_keep);
    assign w_take = i_job_valid && (!r_busy || w_xfer);
    assign w_step = r_busy && (r_phase != PH_DONE);
    assign o_job_take = w_take;

    // chain of compare cells
    for (genvar i = 0; i < NBR; i++) begin : g_cell
        t_slot w_left;
        t_slot w_right;
        logic  w_lower;
        logic  w_upper;
        if (i == 0) begin : g_first
            assign w_left = w_cell[i];
        end else begin : g_mid_l
            assign w_left = w_cell[i-1];
        end
        if (i == NBR - 1) begin : g_last
            assign w_right = w_cell[i];
        end else begin : g_mid_r
            assign w_right = w_cell[i+1];
        end
        assign w_lower = (i < NBR - 1) && (r_phase[0] == 1'(i % 2));
        assign w_upper = (i > 0) && (r_phase[0] == 1'((i + 1) % 2));
        bpnl_sort_cell u_cell (
            .i_clk      (i_clk),
            .i_load     (w_take),
            .i_load_val (i_job.slots[i]),
            .i_step     (w_step),
            .i_lower    (w_lower),
            .i_upper    (w_upper),
            .i_left     (w_left),
            .i_right    (w_right),
            .o_val      (w_cell[i])
        );
    end

    // sort sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= '0;
        end else if (w_take) begin
            r_busy  <= 1'b1;
            r_phase <= '0;
        end else if (w_step) begin
            r_phase <= r_phase + PHASE_W'(1);
        end else if (w_xfer) begin
            r_busy  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_pos <= i_job.pos;
        end
    end

    // first of each run of equal labels survives
    always_comb begin
        w_cnt = '0;
        for (int i = 0; i < NBR; i++) begin
            if (i == 0) begin
                w_keep[i] = w_cell[i].vld;
            end else begin
                w_keep[i] = w_cell[i].vld && (w_cell[i].lbl != w_cell[i-1].lbl);
            end
            w_cnt = w_cnt + CNT_W'(w_keep[i]);
        end
    end

    assign w_adv = !r_keep[0] || i_out_ready;

    // result shift chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep <= '0;
            r_left <= '0;
        end else if (w_xfer) begin
            if (w_cnt == '0) begin
                r_keep <= NBR'(1);
                r_left <= CNT_W'(1);
            end else begin
                r_keep <= w_keep;
                r_left <= w_cnt;
            end
        end else if (w_adv) begin
            r_keep <= {1'b0, r_keep[NBR-1:1]};
            if (r_keep[0]) begin
                r_left <= r_left - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_xfer) begin
            for (int i = 0; i < NBR; i++) begin
                r_ol[i] <= (w_cnt == '0) ? '0 : w_cell[i].lbl;
            end
            r_cnt     <= w_cnt;
            r_out_pos <= r_pos;
        end else if (w_adv) begin
            for (int i = 0; i < NBR - 1; i++) begin
                r_ol[i] <= r_ol[i+1];
            end
        end
    end

    assign o_out_valid               = r_keep[0];
    assign o_out_data.position       = r_out_pos;
    assign o_out_data.neighbor_label = r_ol[0];
    assign o_out_data.neighbor_count = r_cnt;
    assign o_out_data.last           = (r_left == CNT_W'(1));

endmodule

// File: tb/boundary_pixel_neighbor_labels_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boundary_pixel_neighbor_labels_test
// streams label images through the block and checks every boundary pixel's
// sorted neighbor labels against an in-bench predictor, with random gaps on
// both channels and a set of image sizes including the saturating extremes
// ----------------------------------------------------------------------------
module boundary_pixel_neighbor_labels_test;
    import bpnl_pkg::*;

    localparam int HIST_DEPTH = 8196;
    localparam int H_LIMIT    = 4096;
    localparam int W_LIMIT    = 65536;
    localparam int DRAIN      = 40;
    localparam int STALL_MAX  = 2000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd2;

    typedef enum logic {ROW_CFG, ROW_PIX} t_row_kind;

    typedef struct {
        t_row_kind          kind;
        logic [1:0]         idx;
        logic [31:0]        data;
        logic               op;
        logic               typed;
        t_out               want;
    } t_stim_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_in                  i_in_data;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_out                 o_out_data;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    // predictor state
    logic [31:0]  hist_labels [HIST_DEPTH];
    logic [12:0]  cfg_height;
    logic [16:0]  cfg_width;
    int           row_pos;
    int           col_pos;

    t_out         expected_labels [$];
    t_stim_row    stim_table [$];
    int           error_count;
    int           idle_cycles;
    int           pixels_sent;
    bit           no_idle;

    boundary_pixel_neighbor_labels dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // expected results of one accepted pixel request
    function automatic void predict_labels(input logic op, input logic [31:0] lbl);
        int h, w, q, p, cc, cr, nc, nr, cnt, b;
        logic [31:0] v;
        logic [31:0] found [8];
        logic dup;
        t_out r;
        h = (cfg_height == 0) ? 1 : ((cfg_height > H_LIMIT) ? H_LIMIT : int'(cfg_height));
        w = (cfg_width == 0) ? 1 : ((cfg_width > W_LIMIT) ? W_LIMIT : int'(cfg_width));
        q = col_pos * h + row_pos;
        hist_labels[q % HIST_DEPTH] = op ? 32'd0 : lbl;
        if (q >= h + 1) begin
            p  = q - h - 1;
            cc = p / h;
            cr = p % h;
            if (cc < w) begin
                if (hist_labels[p % HIST_DEPTH] == 0) begin
                    cnt = 0;
                    // gather distinct in-bounds neighbor labels, kept ascending
                    for (int dc = -1; dc <= 1; dc++) begin
                        for (int dr = -1; dr <= 1; dr++) begin
                            nc = cc + dc;
                            nr = cr + dr;
                            if ((dc != 0 || dr != 0) && nc >= 0 && nc < w
                                && nr >= 0 && nr < h) begin
                                v = hist_labels[(nc * h + nr) % HIST_DEPTH];
                                dup = 1'b0;
                                for (int k = 0; k < cnt; k++)
                                    if (found[k] == v) dup = 1'b1;
                                if (v != 0 && !dup) begin
                                    b = cnt;
                                    while (b > 0 && found[b-1] > v) begin
                                        found[b] = found[b-1];
                                        b--;
                                    end
                                    found[b] = v;
                                    cnt++;
                                end
                            end
                        end
                    end
                    r.position = POS_W'(p + 1);
                    if (cnt == 0) begin
                        r.neighbor_label = '0;
                        r.neighbor_count = '0;
                        r.last = 1'b1;
                        expected_labels.push_back(r);
                    end else begin
                        for (int k = 0; k < cnt; k++) begin
                            r.neighbor_label = found[k];
                            r.neighbor_count = CNT_W'(cnt);
                            r.last = (k == cnt - 1);
                            expected_labels.push_back(r);
                        end
                    end
                end
                // end of image restarts the stream position
                if (cc == w - 1 && cr == h - 1) begin
                    row_pos = 0;
                    col_pos = 0;
                    return;
                end
            end
        end
        row_pos++;
        if (row_pos >= h) begin
            row_pos = 0;
            col_pos++;
        end
        if (col_pos > w + 1) begin
            col_pos = 0;
            row_pos = 0;
        end
    endfunction

    // pixel request, returns at the accepting edge
    task automatic send_pixel(input logic op, input logic [31:0] lbl);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{op: op, label: lbl};
        do @(posedge i_clk); while (!o_in_ready);
        predict_labels(op, lbl);
    endtask

    // wait for every result, then let the block settle
    task automatic wait_for_idle();
        i_in_valid <= 1'b0;
        while (expected_labels.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        wait_for_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_HEIGHT || idx == REG_WIDTH) begin
            if (idx == REG_HEIGHT) cfg_height = data[12:0];
            else cfg_width = data[16:0];
            row_pos = 0;
            col_pos = 0;
        end
    endtask

    function automatic logic [31:0] pick_label();
        case ($urandom_range(0, 7))
            0, 1, 2: pick_label = 32'd0;
            3:       pick_label = 32'd1;
            4:       pick_label = 32'd2;
            5:       pick_label = 32'd3;
            6:       pick_label = $urandom();
            default: pick_label = 32'hFFFF_FFFF;
        endcase
    endfunction

    // result side: random stalls, field-by-field check
    initial begin
        t_out want;
        int gap;
        i_out_ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            if (expected_labels.size() == 0) begin
                flag_mismatch($sformatf("unexpected result at position %0d",
                                        o_out_data.position));
            end else begin
                want = expected_labels.pop_front();
                if (o_out_data.position !== want.position)
                    flag_mismatch($sformatf("position %0d, want %0d",
                                            o_out_data.position, want.position));
                if (o_out_data.neighbor_label !== want.neighbor_label)
                    flag_mismatch($sformatf("label %0h, want %0h at position %0d",
                        o_out_data.neighbor_label, want.neighbor_label, want.position));
                if (o_out_data.neighbor_count !== want.neighbor_count)
                    flag_mismatch($sformatf("count %0d, want %0d at position %0d",
                        o_out_data.neighbor_count, want.neighbor_count, want.position));
                if (o_out_data.last !== want.last)
                    flag_mismatch($sformatf("last %0b, want %0b at position %0d",
                        o_out_data.last, want.last, want.position));
            end
        end
    end

    // watchdog on handshake progress
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_MAX) begin
            $display("boundary_pixel_neighbor_labels verification failed");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    // stimulus
    initial begin
        int h, w, n, mark;
        t_stim_row row;
        error_count = 0;
        idle_cycles = 0;
        pixels_sent = 0;
        no_idle     = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        cfg_height  = 13'd1;
        cfg_width   = 17'd1;
        row_pos     = 0;
        col_pos     = 0;
        for (int k = 0; k < HIST_DEPTH; k++) hist_labels[k] = '0;

        // single pixel image after reset, lone boundary pixel
        stim_table.push_back('{ROW_PIX, 2'd0, 32'd0, 1'b0, 1'b0, '0});
        stim_table.push_back('{ROW_PIX, 2'd0, 32'hFFFF_FFFF, 1'b1, 1'b0, '0});
        stim_table.push_back('{ROW_PIX, 2'd0, 32'd0, 1'b1, 1'b1,
                               '{position: 29'd1, neighbor_label: 32'd0,
                                 neighbor_count: 4'd0, last: 1'b1}});
        // 3x3 image with extreme labels and a flush inside the image
        stim_table.push_back('{ROW_CFG, REG_HEIGHT, 32'hFFFF_E003, 1'b0, 1'b0, '0});
        stim_table.push_back('{ROW_CFG, REG_WIDTH, 32'hFFFE_0003, 1'b0, 1'b0, '0});
        stim_table.push_back('{ROW_PIX, 2'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, '0});
        stim_table.push_back('{ROW_PIX, 2'd0, 32'd0, 1'b0, 1'b0, '0});
        stim_table.push_back('{ROW_PIX, 2'd0, 32'd1, 1'b0, 1'b0, '0});
        stim_table.push_back('{ROW_PIX, 2'd0, 32'h1234_5678, 1'b1, 1'b0, '0});
        stim_table.push_back('{ROW_PIX, 2'd0, 32'd0, 1'b0, 1'b0, '0});
        stim_table.push_back('{ROW_PIX, 2'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, '0});
        stim_table.push_back('{ROW_PIX, 2'd0, 32'd5, 1'b0, 1'b0, '0});
        stim_table.push_back('{ROW_PIX, 2'd0, 32'd0, 1'b0, 1'b0, '0});
        stim_table.push_back('{ROW_PIX, 2'd0, 32'd5, 1'b0, 1'b0, '0});
        for (int k = 0; k < 4; k++)
            stim_table.push_back('{ROW_PIX, 2'd0, 32'd0, 1'b1, 1'b0, '0});
        // zero sizes act as one, spare index is ignored
        stim_table.push_back('{ROW_CFG, REG_HEIGHT, 32'd0, 1'b0, 1'b0, '0});
        stim_table.push_back('{ROW_CFG, REG_WIDTH, 32'd0, 1'b0, 1'b0, '0});
        stim_table.push_back('{ROW_CFG, REG_SPARE, 32'hA5A5_5A5A, 1'b0, 1'b0, '0});
        stim_table.push_back('{ROW_PIX, 2'd0, 32'd0, 1'b0, 1'b0, '0});
        stim_table.push_back('{ROW_PIX, 2'd0, 32'd0, 1'b1, 1'b0, '0});
        stim_table.push_back('{ROW_PIX, 2'd0, 32'd0, 1'b1, 1'b1,
                               '{position: 29'd1, neighbor_label: 32'd0,
                                 neighbor_count: 4'd0, last: 1'b1}});

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (stim_table[k]) begin
            row = stim_table[k];
            if (row.kind == ROW_CFG) begin
                write_reg(row.idx, row.data);
            end else begin
                mark = expected_labels.size();
                send_pixel(row.op, row.data);
                if (row.typed) begin
                    while (expected_labels.size() > mark) void'(expected_labels.pop_back());
                    expected_labels.push_back(row.want);
                end
            end
        end

        // random small images, mostly complete, some cut short
        while (pixels_sent < 140) begin
            no_idle = ($urandom_range(0, 3) == 0);
            h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
            w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
            write_reg(REG_HEIGHT, ($urandom() & 32'hFFFF_E000) | h);
            write_reg(REG_WIDTH, ($urandom() & 32'hFFFE_0000) | w);
            if (h == 0) h = 1;
            if (w == 0) w = 1;
            n = w * h + h + 1;
            if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
            for (int k = 0; k < n; k++) begin
                if (k >= w * h) send_pixel(1'b1, $urandom());
                else if ($urandom_range(0, 19) == 0) send_pixel(1'b1, $urandom());
                else send_pixel(1'b0, pick_label());
                pixels_sent++;
                // sender holds off once until the result side has caught up
                if (pixels_sent == 70) begin
                    i_in_valid <= 1'b0;
                    while (expected_labels.size() != 0) @(posedge i_clk);
                end
            end
        end

        // tallest image, height saturates to its limit, only its start is sent
        no_idle = 1'b0;
        write_reg(REG_HEIGHT, 32'h0000_1FFF);
        write_reg(REG_WIDTH, 32'd1);
        for (int k = 0; k < 20; k++) begin
            if ($urandom_range(0, 3) == 0) send_pixel(1'b0, 32'd0);
            else send_pixel(1'b0, $urandom_range(0, 1) ? 32'd7 : $urandom());
        end

        // widest image, width saturates, only its start is sent
        write_reg(REG_HEIGHT, 32'd1);
        write_reg(REG_WIDTH, 32'hFFFF_FFFF);
        for (int k = 0; k < 20; k++) send_pixel(1'b0, pick_label());

        write_reg(REG_HEIGHT, 32'd4096);
        write_reg(REG_WIDTH, 32'd65536);
        for (int k = 0; k < 20; k++) send_pixel(1'b0, pick_label());

        wait_for_idle();
        if (error_count == 0)
            $display("boundary_pixel_neighbor_labels verification clean");
        else
            $display("boundary_pixel_neighbor_labels verification failed");
        $finish;
    end

endmodule
